@@ rtl/slm_pkg.sv @@
// Shared constants, types and command/status structs for the stereo RMS
// level meter. No dependencies; every other file imports this package.
package slm_pkg;

  // Field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int HALF_W     = 15;
  localparam int SQ_W       = 29;
  localparam int SUM_W      = 40;
  localparam int FRAMES_W   = 11;
  localparam int DIVR_W     = 12;
  localparam int REM_W      = 11;
  localparam int ROOT_W     = 30;
  localparam int LEVEL_W    = 15;
  localparam int WEIGHT_W   = 16;
  localparam int PROD_W     = 33;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 6;

  // Block length limit and iteration counts
  localparam int MAX_FRAMES  = 1024;
  localparam int DIV_STEPS   = 40;
  localparam int SQRT_STEPS  = 15;

  localparam logic [FRAMES_W-1:0] FRAMES_RESET   = 11'd256;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET   = 16'd4588;
  localparam logic [ROOT_W-1:0]   SQRT_BIT_INIT  = 30'h1000_0000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAMES_PER_BLOCK = 4'd0,
    REG_SMOOTHING_WEIGHT = 4'd1
  } cfg_reg_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load_in;
    logic square;
    logic accum;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic mul;
    logic update;
    logic out_load;
  } slm_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic block_end;
    logic out_free;
  } slm_sts_t;

endpackage

@@ rtl/slm_if.sv @@
// Channel interfaces for the level meter: sample input, result output and
// configuration write. Depends on slm_pkg.
interface slm_in_if;
  import slm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface slm_out_if;
  import slm_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] block_rms;
  logic [LEVEL_W-1:0] smoothed_level;
  modport source (output valid, block_rms, smoothed_level, input ready);
  modport sink   (input valid, block_rms, smoothed_level, output ready);
endinterface

interface slm_cfg_if;
  import slm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/slm_ctrl.sv @@
// Sequencer for the level meter: steps the datapath through accept, square,
// accumulate and, per block, divide, sqrt, smoothing, output. Uses slm_pkg.
module slm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  slm_pkg::slm_sts_t sts,
  output slm_pkg::slm_cmd_t cmd
);
  import slm_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQ   = 9'b000000010,
    S_ACC  = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_SQI  = 9'b000010000,
    S_SQRT = 9'b000100000,
    S_MUL  = 9'b001000000,
    S_UPD  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;

  // Next state, step counter and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SQ;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        step_nxt  = '0;
        state_nxt = sts.block_end ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_SQI;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_MUL;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

@@ rtl/slm_datapath.sv @@
// Datapath of the level meter: config registers, squaring, accumulator,
// shift-subtract divider, digit-by-digit square root, smoothing, output
// register. Driven by slm_ctrl through slm_pkg command/status structs.
module slm_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  slm_pkg::slm_cmd_t                    cmd,
  output slm_pkg::slm_sts_t                    sts,
  input  logic signed [slm_pkg::SAMPLE_W-1:0]  left_sample,
  input  logic signed [slm_pkg::SAMPLE_W-1:0]  right_sample,
  input  logic                                 cfg_valid,
  input  logic [slm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [slm_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [slm_pkg::LEVEL_W-1:0]          block_rms,
  output logic [slm_pkg::LEVEL_W-1:0]          smoothed_level
);
  import slm_pkg::*;

  logic [FRAMES_W-1:0]      frames_cfg_r;
  logic [WEIGHT_W-1:0]      weight_cfg_r;
  logic signed [HALF_W-1:0] half_l_r, half_r_r;
  logic [SQ_W-1:0]          sq_l_r, sq_r_r;
  logic [SUM_W-1:0]         sum_r;
  logic [FRAMES_W-1:0]      count_r;
  logic [SUM_W-1:0]         work_r;
  logic [REM_W-1:0]         rem_r;
  logic [DIVR_W-1:0]        divisor_r;
  logic [ROOT_W-1:0]        x_r, root_r, bit_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [LEVEL_W-1:0]       level_r;
  logic                     out_valid_r;
  logic [LEVEL_W-1:0]       out_rms_r, out_lvl_r;

  logic [FRAMES_W-1:0]        len_eff;
  logic [FRAMES_W-1:0]        frames;
  logic [SUM_W-1:0]           sum_add;
  logic signed [2*HALF_W-1:0] prod_l, prod_r_sq;
  logic [DIVR_W-1:0]          rem_sh;
  logic                       q_bit;
  logic [ROOT_W-1:0]          trial;
  logic signed [LEVEL_W:0]    diff;
  logic signed [WEIGHT_W:0]   weight_s;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic [LEVEL_W-1:0]         level_nxt;

  // Effective block length: zero acts as one, capped at MAX_FRAMES
  always_comb begin
    if (frames_cfg_r == '0) begin
      len_eff = FRAMES_W'(1);
    end else if (frames_cfg_r > FRAMES_W'(MAX_FRAMES)) begin
      len_eff = FRAMES_W'(MAX_FRAMES);
    end else begin
      len_eff = frames_cfg_r;
    end
  end

  assign frames        = count_r + 1'b1;
  assign sts.block_end = (frames >= len_eff);
  assign sts.out_free  = !out_valid_r || out_ready;

  // Squares of the halved samples (always non-negative)
  assign prod_l    = half_l_r * half_l_r;
  assign prod_r_sq = half_r_r * half_r_r;
  assign sum_add   = sum_r + {{(SUM_W-SQ_W){1'b0}}, sq_l_r}
                           + {{(SUM_W-SQ_W){1'b0}}, sq_r_r};

  // One restoring divide step
  assign rem_sh = {rem_r, work_r[SUM_W-1]};
  assign q_bit  = (rem_sh >= divisor_r);

  // One square root step
  assign trial = root_r + bit_r;

  // Smoothing: level += floor((rms - level) * weight / 65536)
  assign diff      = $signed({1'b0, root_r[LEVEL_W-1:0]}) - $signed({1'b0, level_r});
  assign weight_s  = $signed({1'b0, weight_cfg_r});
  assign prod_nxt  = diff * weight_s;
  assign level_nxt = level_r + prod_r[WEIGHT_W +: LEVEL_W];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_cfg_r <= FRAMES_RESET;
      weight_cfg_r <= WEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAMES_PER_BLOCK: frames_cfg_r <= cfg_data[FRAMES_W-1:0];
        REG_SMOOTHING_WEIGHT: weight_cfg_r <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Block state: accumulator, frame counter, smoothed level, output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      count_r     <= '0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accum) begin
        if (sts.block_end) begin
          sum_r   <= '0;
          count_r <= '0;
        end else begin
          sum_r   <= sum_add;
          count_r <= frames;
        end
      end
      if (cmd.update) begin
        level_r <= level_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      half_l_r <= left_sample[SAMPLE_W-1:1];
      half_r_r <= right_sample[SAMPLE_W-1:1];
    end
    if (cmd.square) begin
      sq_l_r <= prod_l[SQ_W-1:0];
      sq_r_r <= prod_r_sq[SQ_W-1:0];
    end
    if (cmd.accum && sts.block_end) begin
      work_r    <= sum_add;
      rem_r     <= '0;
      divisor_r <= {frames, 1'b0};
    end else if (cmd.div_step) begin
      work_r <= {work_r[SUM_W-2:0], q_bit};
      rem_r  <= q_bit ? REM_W'(rem_sh - divisor_r) : rem_sh[REM_W-1:0];
    end
    if (cmd.sqrt_init) begin
      x_r    <= work_r[ROOT_W-1:0];
      root_r <= '0;
      bit_r  <= SQRT_BIT_INIT;
    end else if (cmd.sqrt_step) begin
      if (x_r >= trial) begin
        x_r    <= x_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.out_load) begin
      out_rms_r <= root_r[LEVEL_W-1:0];
      out_lvl_r <= level_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign block_rms      = out_rms_r;
  assign smoothed_level = out_lvl_r;

endmodule

@@ rtl/stereo_rms_level_meter_core.sv @@
// Top level of the stereo RMS level meter: joins slm_ctrl and slm_datapath
// to the channel interfaces. Depends on slm_pkg and slm_if.
//
//   channel | dir | payload                         | accepted when
//   in_ch   | in  | left_sample, right_sample       | valid && ready
//   out_ch  | out | block_rms, smoothed_level       | valid && ready
//   cfg_ch  | in  | index, data                     | valid && ready (ready tied high)
//
// A frame passes through accept, square and accumulate; one item at a time.
// The frame that ends a block adds the divider steps, the square root setup
// and steps, then the smoothing multiply, level update and output load.
// Reset is synchronous: accumulator, frame count and level clear, config
// registers return to 256 frames and weight 4588.
// A held result stalls the next block end; no frames are accepted meanwhile.
module stereo_rms_level_meter_core (
  input logic        clk,
  input logic        rst_n,
  slm_in_if.sink     in_ch,
  slm_out_if.source  out_ch,
  slm_cfg_if.sink    cfg_ch
);
  import slm_pkg::*;

  slm_cmd_t cmd;
  slm_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  slm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  slm_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .left_sample    (in_ch.left_sample),
    .right_sample   (in_ch.right_sample),
    .cfg_valid      (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .block_rms      (out_ch.block_rms),
    .smoothed_level (out_ch.smoothed_level)
  );

endmodule

@@ rtl/slm_chk.sv @@
// Port-level checker for the stereo RMS level meter, bound to the top level.
// Depends on slm_pkg.
module slm_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [slm_pkg::LEVEL_W-1:0]   block_rms,
  input logic [slm_pkg::LEVEL_W-1:0]   smoothed_level
);
  import slm_pkg::*;

  // A held result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(block_rms) && $stable(smoothed_level))
    else $error("result payload changed while stalled");

  // RMS of halved Q1.15 samples never exceeds one half
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> block_rms <= LEVEL_W'(16384))
    else $error("block_rms out of range");

  // Smoothed level stays between old level and RMS, so within range
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> smoothed_level <= LEVEL_W'(16384))
    else $error("smoothed_level out of range");

  // One frame at a time: after an accepted item the input is busy
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

endmodule

bind stereo_rms_level_meter_core slm_chk u_slm_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .block_rms      (out_ch.block_rms),
  .smoothed_level (out_ch.smoothed_level)
);
